/* rtl/core/stu_pkg.sv */
// Shared types, constants and command codes for the series transcendental unit.
`timescale 1ns / 1ps
`default_nettype none
package stu_pkg;

	localparam int STU_FRAC_BITS = 16;
	localparam int STU_DIV_W     = 64;
	localparam logic [63:0] STU_PI_Q32 = 64'd13493037705;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITERS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

	localparam logic [2:0] FN_EXP  = 3'd0;
	localparam logic [2:0] FN_LOG  = 3'd1;
	localparam logic [2:0] FN_SIN  = 3'd2;
	localparam logic [2:0] FN_COS  = 3'd3;
	localparam logic [2:0] FN_TANH = 3'd4;

	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_EA_X     = 5'd2;
	localparam logic [4:0] OP_EX_INIT  = 5'd3;
	localparam logic [4:0] OP_EX_MUL   = 5'd4;
	localparam logic [4:0] OP_EX_DIV   = 5'd5;
	localparam logic [4:0] OP_EX_ACC   = 5'd6;
	localparam logic [4:0] OP_EX_FIN   = 5'd7;
	localparam logic [4:0] OP_EX_RDIV  = 5'd8;
	localparam logic [4:0] OP_EX_RCP   = 5'd9;
	localparam logic [4:0] OP_EXQ_FIN  = 5'd10;
	localparam logic [4:0] OP_LOG_INIT = 5'd11;
	localparam logic [4:0] OP_LOG_DIV  = 5'd12;
	localparam logic [4:0] OP_LOG_UPD  = 5'd13;
	localparam logic [4:0] OP_RED_DIV  = 5'd14;
	localparam logic [4:0] OP_TRG_RED  = 5'd15;
	localparam logic [4:0] OP_TRG_SQ   = 5'd16;
	localparam logic [4:0] OP_TRG_INIT = 5'd17;
	localparam logic [4:0] OP_TRG_ACC  = 5'd18;
	localparam logic [4:0] OP_TRG_DIV  = 5'd19;
	localparam logic [4:0] OP_TRG_TERM = 5'd20;
	localparam logic [4:0] OP_TNH_INIT = 5'd21;
	localparam logic [4:0] OP_TNH_E1   = 5'd22;
	localparam logic [4:0] OP_TNH_DIV  = 5'd23;
	localparam logic [4:0] OP_TNH_FIN  = 5'd24;
	localparam logic [4:0] OP_OUT      = 5'd25;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] x_value;
	} stu_in_t;

	typedef struct packed {
		logic signed [31:0] y_value;
		logic               domain_error;
		logic               saturated;
	} stu_out_t;

	typedef struct packed {
		logic [4:0] op;
	} stu_cmd_t;

	typedef struct packed {
		logic [2:0] sel;
		logic       x_nonpos;
		logic       nt_zero;
		logic       tanh_clamp;
		logic       series_end;
		logic       brk;
		logic       neg;
		logic       div_done;
		logic       log_conv;
		logic       k_done;
	} stu_stat_t;

endpackage
`default_nettype wire

/* rtl/core/stu_div.sv */
// Unsigned iterative divider, two quotient bits per cycle, with remainder.
`timescale 1ns / 1ps
`default_nettype none
module stu_div
	import stu_pkg::*;
#(
	parameter int DIV_W = STU_DIV_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quot,
	output logic [DIV_W-1:0]      rem
);
	localparam int CNT_W = $clog2(DIV_W / 2);

	logic [DIV_W-1:0] q_q, d_q, q1, q2;
	logic [DIV_W:0]   r_q, r1, r1b, r2, r2b;
	logic             ge1, ge2, run_q, done_q;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		r1  = {r_q[DIV_W-1:0], q_q[DIV_W-1]};
		ge1 = r1 >= {1'b0, d_q};
		r1b = ge1 ? r1 - {1'b0, d_q} : r1;
		q1  = {q_q[DIV_W-2:0], ge1};
		r2  = {r1b[DIV_W-1:0], q1[DIV_W-1]};
		ge2 = r2 >= {1'b0, d_q};
		r2b = ge2 ? r2 - {1'b0, d_q} : r2;
		q2  = {q1[DIV_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W / 2 - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (run_q) begin
			q_q <= q2;
			r_q <= r2b;
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q[DIV_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/stu_dp.sv */
// Datapath: operand and series registers, shared multiplier and divider, config registers.
`timescale 1ns / 1ps
`default_nettype none
module stu_dp
	import stu_pkg::*;
#(
	parameter int FRAC_BITS = STU_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stu_in_t              req,
	input  wire stu_cmd_t             cmd,
	output stu_stat_t                 stat,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output logic                      done,
	output stu_out_t                  rsp
);
	localparam int F = FRAC_BITS;
	localparam logic [63:0] ONE    = 64'd1 << F;
	localparam logic [63:0] PI     = (STU_PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);
	localparam logic [63:0] TWO_PI = PI << 1;
	localparam logic [63:0] TEN    = ONE * 64'd10;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? $unsigned(-v) : $unsigned(v);
	endfunction

	logic [3:0]         terms_q;
	logic [4:0]         iters_q;
	logic [15:0]        thr_q;

	logic signed [31:0] x_q, r_q;
	logic [2:0]         sel_q;
	logic signed [32:0] ea_q;
	logic [31:0]        a_q, res_q, e_q, ep_q, r2_q;
	logic               neg_q, brk_q, ovf_q, sat_q, derr_q, done_q;
	logic signed [47:0] term_q, qn;
	logic [4:0]         i_q, k_q;
	logic [63:0]        prod_q, prod_d, dvd, dvs, quot, rem, sum;
	logic signed [63:0] y_q, x64, e64, ep64, diff_log, diff_tnh, qs, ynew, rs0, rs1, rs2;
	logic signed [63:0] lin, qt;
	logic [63:0]        r_abs, t_abs;
	logic [31:0]        mul_a, mul_b;
	logic [9:0]         tri_den;
	logic               div_start, div_done;
	stu_out_t           rsp_q;

	assign x64      = {{32{x_q[31]}}, x_q};
	assign e64      = {32'd0, e_q};
	assign ep64     = {32'd0, ep_q};
	assign diff_log = e64 - x64;
	assign diff_tnh = ep64 - e64;
	assign tri_den  = ({5'd0, i_q} + 10'd1) * ({5'd0, i_q} + 10'd2);
	assign qs       = diff_log[63] ? -$signed(quot) : $signed(quot);
	assign ynew     = y_q - qs;
	assign qt       = diff_tnh[63] ? -$signed(quot) : $signed(quot);
	assign lin      = x64 - $signed(ONE);
	assign sum      = {32'd0, res_q} + quot;
	assign qn       = $signed(quot[47:0]);
	assign rs0      = x_q[31] ? -$signed(rem) : $signed(rem);
	assign rs1      = rs0[63] ? rs0 + $signed(TWO_PI) : rs0;
	assign rs2      = (rs1 > $signed(PI)) ? rs1 - $signed(TWO_PI) : rs1;
	assign r_abs    = mag64({{32{r_q[31]}}, r_q});
	assign t_abs    = mag64({{16{term_q[47]}}, term_q});

	always_comb begin
		mul_a = term_q[31:0];
		mul_b = a_q;
		case (cmd.op)
			OP_TRG_SQ: begin
				mul_a = r_abs[31:0];
				mul_b = r_abs[31:0];
			end
			OP_TRG_ACC: begin
				mul_a = t_abs[31:0];
				mul_b = r2_q;
			end
			default: ;
		endcase
	end
	assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};

	always_comb begin
		div_start = 1'b1;
		dvd       = '0;
		dvs       = 64'd1;
		case (cmd.op)
			OP_EX_DIV: begin
				dvd = prod_q >> F;
				dvs = {59'd0, i_q};
			end
			OP_EX_RDIV: begin
				dvd = ONE << F;
				dvs = {32'd0, res_q};
			end
			OP_LOG_DIV: begin
				dvd = mag64(diff_log) << F;
				dvs = (e_q == '0) ? 64'd1 : e64;
			end
			OP_RED_DIV: begin
				dvd = mag64(x64);
				dvs = TWO_PI;
			end
			OP_TRG_DIV: begin
				dvd = prod_q >> F;
				dvs = {54'd0, tri_den};
			end
			OP_TNH_DIV: begin
				dvd = mag64(diff_tnh) << F;
				dvs = ep64 + e64;
			end
			default: div_start = 1'b0;
		endcase
	end

	stu_div #(.DIV_W(STU_DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terms_q <= 4'd15;
			iters_q <= 5'd20;
			thr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TERMS:  terms_q <= cfg_wdata[3:0];
				CFG_ITERS:  iters_q <= cfg_wdata[4:0];
				CFG_THRESH: thr_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				x_q    <= req.x_value;
				sel_q  <= req.req_type;
				y_q    <= '0;
				derr_q <= 1'b0;
				sat_q  <= 1'b0;
			end
			OP_EA_X: ea_q <= {x_q[31], x_q};
			OP_EX_INIT: begin
				neg_q  <= ea_q[32];
				a_q    <= ea_q[32] ? 32'(-ea_q) : ea_q[31:0];
				res_q  <= ONE[31:0];
				term_q <= $signed(ONE[47:0]);
				i_q    <= 5'd1;
				brk_q  <= 1'b0;
				ovf_q  <= 1'b0;
			end
			OP_EX_MUL: prod_q <= prod_d;
			OP_EX_ACC: begin
				term_q <= qn;
				i_q    <= i_q + 5'd1;
				if (sum > 64'd2147483647) begin
					res_q <= 32'h8000_0000;
					ovf_q <= 1'b1;
					brk_q <= 1'b1;
				end else begin
					res_q <= sum[31:0];
					brk_q <= quot <= {48'd0, thr_q};
				end
			end
			OP_EX_FIN: e_q <= res_q;
			OP_EX_RCP: begin
				e_q   <= quot[31:0];
				ovf_q <= 1'b0;
			end
			OP_EXQ_FIN: begin
				if (ovf_q) begin
					y_q   <= I32_MAX;
					sat_q <= 1'b1;
				end else begin
					y_q <= e64;
				end
			end
			OP_LOG_INIT: begin
				k_q   <= '0;
				sat_q <= 1'b0;
				ea_q  <= lin[32:0];
				if (x_q <= 0) begin
					y_q    <= I32_MIN;
					derr_q <= 1'b1;
				end else begin
					y_q <= lin;
				end
			end
			OP_LOG_UPD: begin
				k_q <= k_q + 5'd1;
				if (ynew > I32_MAX) begin
					y_q   <= I32_MAX;
					ea_q  <= I32_MAX[32:0];
					sat_q <= 1'b1;
				end else if (ynew < I32_MIN) begin
					y_q   <= I32_MIN;
					ea_q  <= I32_MIN[32:0];
					sat_q <= 1'b1;
				end else begin
					y_q   <= ynew;
					ea_q  <= ynew[32:0];
					sat_q <= 1'b0;
				end
			end
			OP_TRG_RED: r_q <= rs2[31:0];
			OP_TRG_SQ: prod_q <= prod_d;
			OP_TRG_INIT: begin
				r2_q  <= 32'(prod_q >> F);
				brk_q <= 1'b0;
				if (sel_q == FN_SIN) begin
					term_q <= {{16{r_q[31]}}, r_q};
					i_q    <= 5'd1;
				end else begin
					term_q <= $signed(ONE[47:0]);
					i_q    <= 5'd0;
				end
			end
			OP_TRG_ACC: begin
				y_q    <= y_q + {{16{term_q[47]}}, term_q};
				prod_q <= prod_d;
			end
			OP_TRG_TERM: begin
				term_q <= term_q[47] ? qn : -qn;
				brk_q  <= quot <= {48'd0, thr_q};
				i_q    <= i_q + 5'd2;
			end
			OP_TNH_INIT: begin
				ea_q <= {x_q[31], x_q};
				y_q  <= x_q[31] ? -$signed(ONE) : $signed(ONE);
			end
			OP_TNH_E1: begin
				ep_q <= e_q;
				ea_q <= -{x_q[31], x_q};
			end
			OP_TNH_FIN: y_q <= qt;
			OP_OUT: begin
				rsp_q.y_value      <= y_q[31:0];
				rsp_q.domain_error <= derr_q;
				rsp_q.saturated    <= sat_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.sel        = sel_q;
		stat.x_nonpos   = x_q <= 0;
		stat.nt_zero    = iters_q == '0;
		stat.tanh_clamp = (x64 > $signed(TEN)) || (x64 < -$signed(TEN));
		stat.series_end = i_q > {1'b0, terms_q};
		stat.brk        = brk_q;
		stat.neg        = neg_q;
		stat.div_done   = div_done;
		stat.log_conv   = mag64(diff_log) <= {48'd0, thr_q};
		stat.k_done     = k_q == iters_q;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

/* rtl/core/stu_ctrl.sv */
// Controller: sequences series, Newton and reduction steps on the datapath.
`timescale 1ns / 1ps
`default_nettype none
module stu_ctrl
	import stu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire stu_stat_t stat,
	output stu_cmd_t       cmd,
	output logic           busy
);
	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_DISP     = 5'd1;
	localparam logic [4:0] S_DWAIT    = 5'd2;
	localparam logic [4:0] S_EX_INIT  = 5'd3;
	localparam logic [4:0] S_EX_CHK   = 5'd4;
	localparam logic [4:0] S_EX_MUL   = 5'd5;
	localparam logic [4:0] S_EX_DIV   = 5'd6;
	localparam logic [4:0] S_EX_ACC   = 5'd7;
	localparam logic [4:0] S_EX_FIN   = 5'd8;
	localparam logic [4:0] S_EX_RCP   = 5'd9;
	localparam logic [4:0] S_EXQ_FIN  = 5'd10;
	localparam logic [4:0] S_LOG_STEP = 5'd11;
	localparam logic [4:0] S_LOG_UPD  = 5'd12;
	localparam logic [4:0] S_LOG_CHK  = 5'd13;
	localparam logic [4:0] S_TRG_RED  = 5'd14;
	localparam logic [4:0] S_TRG_SQ   = 5'd15;
	localparam logic [4:0] S_TRG_INIT = 5'd16;
	localparam logic [4:0] S_TRG_CHK  = 5'd17;
	localparam logic [4:0] S_TRG_ACC  = 5'd18;
	localparam logic [4:0] S_TRG_DIV  = 5'd19;
	localparam logic [4:0] S_TRG_TERM = 5'd20;
	localparam logic [4:0] S_TNH_E1   = 5'd21;
	localparam logic [4:0] S_TNH_E2   = 5'd22;
	localparam logic [4:0] S_TNH_FIN  = 5'd23;
	localparam logic [4:0] S_DONE     = 5'd24;

	logic [4:0] state_q, state_d, eret_q, eret_d, dret_q, dret_d;

	always_comb begin
		state_d = state_q;
		eret_d  = eret_q;
		dret_d  = dret_q;
		cmd.op  = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.sel)
					FN_EXP: begin
						cmd.op  = OP_EA_X;
						state_d = S_EX_INIT;
						eret_d  = S_EXQ_FIN;
					end
					FN_LOG: begin
						cmd.op = OP_LOG_INIT;
						if (stat.x_nonpos || stat.nt_zero) begin
							state_d = S_DONE;
						end else begin
							state_d = S_EX_INIT;
							eret_d  = S_LOG_STEP;
						end
					end
					FN_SIN, FN_COS: begin
						cmd.op  = OP_RED_DIV;
						state_d = S_DWAIT;
						dret_d  = S_TRG_RED;
					end
					FN_TANH: begin
						cmd.op = OP_TNH_INIT;
						if (stat.tanh_clamp) begin
							state_d = S_DONE;
						end else begin
							state_d = S_EX_INIT;
							eret_d  = S_TNH_E1;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_DWAIT: begin
				if (stat.div_done) state_d = dret_q;
			end
			S_EX_INIT: begin
				cmd.op  = OP_EX_INIT;
				state_d = S_EX_CHK;
			end
			S_EX_CHK: begin
				state_d = (stat.brk || stat.series_end) ? S_EX_FIN : S_EX_MUL;
			end
			S_EX_MUL: begin
				cmd.op  = OP_EX_MUL;
				state_d = S_EX_DIV;
			end
			S_EX_DIV: begin
				cmd.op  = OP_EX_DIV;
				state_d = S_DWAIT;
				dret_d  = S_EX_ACC;
			end
			S_EX_ACC: begin
				cmd.op  = OP_EX_ACC;
				state_d = S_EX_CHK;
			end
			S_EX_FIN: begin
				if (stat.neg) begin
					cmd.op  = OP_EX_RDIV;
					state_d = S_DWAIT;
					dret_d  = S_EX_RCP;
				end else begin
					cmd.op  = OP_EX_FIN;
					state_d = eret_q;
				end
			end
			S_EX_RCP: begin
				cmd.op  = OP_EX_RCP;
				state_d = eret_q;
			end
			S_EXQ_FIN: begin
				cmd.op  = OP_EXQ_FIN;
				state_d = S_DONE;
			end
			S_LOG_STEP: begin
				cmd.op  = OP_LOG_DIV;
				state_d = S_DWAIT;
				dret_d  = S_LOG_UPD;
			end
			S_LOG_UPD: begin
				cmd.op  = OP_LOG_UPD;
				state_d = S_EX_INIT;
				eret_d  = S_LOG_CHK;
			end
			S_LOG_CHK: begin
				state_d = (stat.log_conv || stat.k_done) ? S_DONE : S_LOG_STEP;
			end
			S_TRG_RED: begin
				cmd.op  = OP_TRG_RED;
				state_d = S_TRG_SQ;
			end
			S_TRG_SQ: begin
				cmd.op  = OP_TRG_SQ;
				state_d = S_TRG_INIT;
			end
			S_TRG_INIT: begin
				cmd.op  = OP_TRG_INIT;
				state_d = S_TRG_CHK;
			end
			S_TRG_CHK: begin
				state_d = (stat.brk || stat.series_end) ? S_DONE : S_TRG_ACC;
			end
			S_TRG_ACC: begin
				cmd.op  = OP_TRG_ACC;
				state_d = S_TRG_DIV;
			end
			S_TRG_DIV: begin
				cmd.op  = OP_TRG_DIV;
				state_d = S_DWAIT;
				dret_d  = S_TRG_TERM;
			end
			S_TRG_TERM: begin
				cmd.op  = OP_TRG_TERM;
				state_d = S_TRG_CHK;
			end
			S_TNH_E1: begin
				cmd.op  = OP_TNH_E1;
				state_d = S_EX_INIT;
				eret_d  = S_TNH_E2;
			end
			S_TNH_E2: begin
				cmd.op  = OP_TNH_DIV;
				state_d = S_DWAIT;
				dret_d  = S_TNH_FIN;
			end
			S_TNH_FIN: begin
				cmd.op  = OP_TNH_FIN;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.op  = OP_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eret_q  <= S_IDLE;
			dret_q  <= S_IDLE;
		end else begin
			state_q <= state_d;
			eret_q  <= eret_d;
			dret_q  <= dret_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule
`default_nettype wire

/* rtl/core/series_transcendental_unit.sv */
// Top level of the series transcendental unit: controller, datapath and port wiring.
// One word is taken when start is high and busy is low; its result appears on rsp with
// done high for a single cycle, and the receiver cannot stall it. Words are handled
// one at a time. Every series term and every division goes through one shared divider
// that retires two quotient bits per cycle, and the controller waits for each division
// to finish. Log runs a series exp in each of its Newton steps. Configuration
// writes are taken at any time but must only be issued while busy is low.
`timescale 1ns / 1ps
`default_nettype none
module series_transcendental_unit
	import stu_pkg::*;
#(
	parameter int FRAC_BITS = STU_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire stu_in_t              req,
	output logic                      done,
	output stu_out_t                  rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);
	stu_cmd_t  cmd;
	stu_stat_t stat;

	stu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	stu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

/* rtl/core/stu_chk.sv */
// Port-level checker for the series transcendental unit and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module stu_chk
	import stu_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     done,
	input wire stu_out_t rsp
);
	// An accepted word makes the unit busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// A result is shown for one cycle only.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word held for more than one cycle");

	// A result follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without work in progress");

	// A domain error returns the most negative value and is never saturated.
	a_domain_err: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.domain_error |-> rsp.y_value == 32'sh8000_0000 && !rsp.saturated)
		else $error("domain error word malformed");

endmodule

bind series_transcendental_unit stu_chk u_stu_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire

/* tb/series_transcendental_unit_checker.sv */
// Predictor and result checker for the series transcendental unit.
`timescale 1ns / 1ps
`default_nettype none
module series_transcendental_unit_checker
	import stu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire stu_in_t              req,
	input  wire logic                 done,
	input  wire stu_out_t             rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output int                        errors,
	output int                        pending,
	output int                        results
);

	localparam longint ONE_Q   = longint'(1) << STU_FRAC_BITS;
	localparam longint EXP_CAP = longint'(1) << 31;
	localparam longint Y_MAX   = 64'sd2147483647;
	localparam longint Y_MIN   = -64'sd2147483648;

	logic [3:0]  terms_q;
	logic [4:0]  iters_q;
	logic [15:0] thresh_q;
	stu_out_t    expected_q[$];

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint exp_of_nonneg(longint a, output bit ovf);
		longint sum;
		longint term;
		sum = ONE_Q;
		term = ONE_Q;
		ovf = 0;
		for (int i = 1; i <= terms_q; i++) begin
			term = (term * a) / (longint'(i) << STU_FRAC_BITS);
			sum += term;
			if (sum > Y_MAX) begin
				sum = EXP_CAP;
				ovf = 1;
				break;
			end
			if (term <= longint'(thresh_q))
				break;
		end
		return sum;
	endfunction

	function automatic longint exp_q(longint a, output bit ovf);
		bit unused;
		longint e;
		if (a < 0) begin
			e = exp_of_nonneg(-a, unused);
			ovf = 0;
			return (ONE_Q * ONE_Q) / e;
		end
		return exp_of_nonneg(a, ovf);
	endfunction

	function automatic longint reduce_angle(longint x);
		longint pi_q;
		longint r;
		pi_q = longint'((STU_PI_Q32 + (64'd1 << (31 - STU_FRAC_BITS))) >> (32 - STU_FRAC_BITS));
		r = x % (2 * pi_q);
		if (r < 0)
			r += 2 * pi_q;
		if (r > pi_q)
			r -= 2 * pi_q;
		return r;
	endfunction

	function automatic longint trig_series(longint r, longint first, int i0);
		longint sum;
		longint term;
		longint r2;
		sum = 0;
		term = first;
		r2 = (r * r) / ONE_Q;
		for (int i = i0; i <= terms_q; i += 2) begin
			sum += term;
			term = -(term * r2) / (longint'(i + 1) * longint'(i + 2) * ONE_Q);
			if (magnitude(term) <= longint'(thresh_q))
				break;
		end
		return sum;
	endfunction

	function automatic stu_out_t predict_function(stu_in_t w);
		stu_out_t o;
		longint x;
		longint y;
		longint e;
		longint ep;
		longint en;
		bit ovf;
		x = longint'(w.x_value);
		y = 0;
		o = '0;
		case (w.req_type)
			FN_EXP: begin
				y = exp_q(x, ovf);
				if (ovf) begin
					y = Y_MAX;
					o.saturated = 1;
				end
			end
			FN_LOG: begin
				if (x <= 0) begin
					y = Y_MIN;
					o.domain_error = 1;
				end else begin
					y = x - ONE_Q;
					for (int k = 0; k < iters_q; k++) begin
						e = exp_q(y, ovf);
						y -= ((e - x) * ONE_Q) / (e > 0 ? e : 1);
						o.saturated = 0;
						if (y > Y_MAX) begin
							y = Y_MAX;
							o.saturated = 1;
						end else if (y < Y_MIN) begin
							y = Y_MIN;
							o.saturated = 1;
						end
						if (magnitude(exp_q(y, ovf) - x) <= longint'(thresh_q))
							break;
					end
				end
			end
			FN_SIN: y = trig_series(reduce_angle(x), reduce_angle(x), 1);
			FN_COS: y = trig_series(reduce_angle(x), ONE_Q, 0);
			FN_TANH: begin
				if (x > 10 * ONE_Q)
					y = ONE_Q;
				else if (x < -10 * ONE_Q)
					y = -ONE_Q;
				else begin
					ep = exp_q(x, ovf);
					en = exp_q(-x, ovf);
					y = ((ep - en) * ONE_Q) / (ep + en);
				end
			end
			default: y = 0;
		endcase
		o.y_value = y[31:0];
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		stu_out_t exp_w;
		if (!arst_n) begin
			terms_q <= 4'd15;
			iters_q <= 5'd20;
			thresh_q <= 16'd0;
			errors <= 0;
			results <= 0;
			expected_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_TERMS:  terms_q <= cfg_wdata[3:0];
					CFG_ITERS:  iters_q <= cfg_wdata[4:0];
					CFG_THRESH: thresh_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (start && !busy)
				expected_q.push_back(predict_function(req));
			if (done) begin
				results <= results + 1;
				if (expected_q.size() == 0) begin
					$error("result word with nothing expected: y_value %0d", rsp.y_value);
					errors <= errors + 1;
				end else begin
					exp_w = expected_q.pop_front();
					if (rsp.y_value !== exp_w.y_value)
						$error("y_value expected %0d actual %0d", exp_w.y_value, rsp.y_value);
					if (rsp.domain_error !== exp_w.domain_error)
						$error("domain_error expected %0b actual %0b",
							exp_w.domain_error, rsp.domain_error);
					if (rsp.saturated !== exp_w.saturated)
						$error("saturated expected %0b actual %0b",
							exp_w.saturated, rsp.saturated);
					if (rsp.y_value !== exp_w.y_value || rsp.domain_error !== exp_w.domain_error
							|| rsp.saturated !== exp_w.saturated)
						errors <= errors + 1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* tb/series_transcendental_unit_tb.sv */
// Testbench top for the series transcendental unit: stimulus, configuration and verdict.
`timescale 1ns / 1ps
`default_nettype none
module series_transcendental_unit_tb;
	import stu_pkg::*;

	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] TEN = 32'sh000A_0000;
	localparam logic signed [31:0] MAX_X = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN_X = 32'sh8000_0000;
	localparam logic signed [31:0] HALF_PI = 32'sd102944;
	localparam logic signed [31:0] PI_Q = 32'sd205887;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 start = 0;
	logic                 busy;
	stu_in_t              req = '0;
	logic                 done;
	stu_out_t             rsp;
	logic                 cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	int                   errors;
	int                   pending;
	int                   results;
	int                   sent = 0;
	int                   idle_pct = 0;

	always #10 clk = ~clk;

	series_transcendental_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req), .done(done),
		.rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	series_transcendental_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req), .done(done),
		.rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .results(results)
	);

	task automatic send_word(logic [2:0] fn, logic signed [31:0] x);
		if ($urandom_range(99) < idle_pct) begin
			start = 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		start = 1;
		req.req_type = fn;
		req.x_value = x;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_idle();
		start = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we = 1;
		cfg_idx = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic send_random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20)
			send_word(FN_EXP, $signed($urandom_range(0, 2 * 21 * 65536)) - 21 * 65536);
		else if (pick < 36)
			send_word(FN_LOG, $signed($urandom_range(1, 32'h7FFF_FFFF)) >>> $urandom_range(0, 30));
		else if (pick < 52)
			send_word(FN_SIN, $signed($urandom()) >>> $urandom_range(0, 14));
		else if (pick < 68)
			send_word(FN_COS, $signed($urandom()) >>> $urandom_range(0, 14));
		else if (pick < 82)
			send_word(FN_TANH, $signed($urandom_range(0, 2 * 12 * 65536)) - 12 * 65536);
		else
			send_word(3'($urandom_range(0, 7)), $signed($urandom()));
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		idle_pct = 34;
		send_word(FN_EXP, 0);
		send_word(FN_EXP, ONE);
		send_word(FN_EXP, -ONE);
		send_word(FN_EXP, MAX_X);
		send_word(FN_EXP, MIN_X);
		send_word(FN_LOG, 0);
		send_word(FN_LOG, -ONE);
		send_word(FN_LOG, MIN_X);
		send_word(FN_LOG, 1);
		send_word(FN_LOG, ONE);
		send_word(FN_LOG, MAX_X);
		send_word(FN_SIN, HALF_PI);
		send_word(FN_SIN, MAX_X);
		send_word(FN_SIN, MIN_X);
		send_word(FN_COS, 0);
		send_word(FN_COS, PI_Q);
		send_word(FN_TANH, TEN);
		send_word(FN_TANH, -TEN);
		send_word(FN_TANH, TEN + 1);
		send_word(FN_TANH, -TEN - 1);
		send_word(FN_TANH, 0);
		send_word(3'd5, ONE);
		send_word(3'd6, -ONE);
		send_word(3'd7, MAX_X);
		drain_and_idle();

		write_reg(CFG_TERMS, 16'd0);
		write_reg(CFG_ITERS, 16'd0);
		send_word(FN_EXP, ONE);
		send_word(FN_LOG, 3 * ONE);
		send_word(FN_SIN, ONE);
		send_word(FN_COS, ONE);
		drain_and_idle();

		write_reg(CFG_TERMS, 16'd15);
		write_reg(CFG_ITERS, 16'd20);
		write_reg(CFG_THRESH, 16'd0);
		repeat (30) send_random_word();
		drain_and_idle();

		idle_pct = 88;
		write_reg(CFG_TERMS, 16'd1);
		write_reg(CFG_ITERS, 16'd1);
		write_reg(CFG_THRESH, 16'hFFFF);
		repeat (40) send_random_word();
		drain_and_idle();

		idle_pct = 0;
		write_reg(CFG_TERMS, 16'($urandom_range(1, 15)));
		write_reg(CFG_ITERS, 16'($urandom_range(1, 20)));
		write_reg(CFG_THRESH, 16'($urandom_range(0, 64)));
		repeat (30) send_random_word();
		drain_and_idle();

		write_reg(CFG_TERMS, 16'($urandom_range(1, 15)));
		write_reg(CFG_ITERS, 16'($urandom_range(1, 6)));
		write_reg(CFG_THRESH, 16'($urandom()));
		repeat (30) send_random_word();
		drain_and_idle();

		$display("Sent %0d words, checked %0d results over six register settings,", sent, results);
		$display("with sender gaps at 34%%, 88%% and none.");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(64'd20 * 64'd20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* series_transcendental_unit.f */
rtl/core/stu_pkg.sv
rtl/core/stu_div.sv
rtl/core/stu_dp.sv
rtl/core/stu_ctrl.sv
rtl/core/series_transcendental_unit.sv
rtl/core/stu_chk.sv
tb/series_transcendental_unit_checker.sv
tb/series_transcendental_unit_tb.sv
